/* sv/srec_pkg.sv */
// package with character codes, record kinds and decode helpers of the s-record parser
package srec_pkg;

   localparam int unsigned POS_WIDTH = 10;

   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_ONE = 8'h31;
   localparam logic [7:0] CHAR_TWO = 8'h32;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_LINE_END = 8'h0a;

   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

   localparam logic RESULT_WRITE = 1'b0;
   localparam logic RESULT_ERROR = 1'b1;

   typedef enum logic [1:0] {
      REC_NONE = 2'd0,
      REC_S1 = 2'd1,
      REC_S2 = 2'd2,
      REC_S3 = 2'd3
   } record_kind_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h57);
      end
      return v;
   endfunction

   // first data character position: header of 4 plus two digits per address byte
   function automatic logic [POS_WIDTH-1:0] data_start(input record_kind_type kind);
      logic [POS_WIDTH-1:0] s;
      unique case (kind)
         REC_S1: s = POS_WIDTH'(8);
         REC_S2: s = POS_WIDTH'(10);
         REC_S3: s = POS_WIDTH'(12);
         default: s = POS_WIDTH'(0);
      endcase
      return s;
   endfunction

   // address bytes plus checksum
   function automatic logic [7:0] overhead(input record_kind_type kind);
      return 8'({6'd0, kind} + 8'd2);
   endfunction

endpackage

/* sv/srec_record_parser_top.sv */
// s-record parser: decodes one character per transaction into memory byte writes
// a result is registered and appears in the cycle after the character transaction that completes it
// throughput: one character per cycle; the single registered decode stage sets this,
//    stalled only while an unread result waits and rsp_ready is low
// reset (synchronous, active high) returns to line start, clears the halt flag and
//    drops any pending result
module srec_record_parser_top
   import srec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_data_byte
);

   logic [POS_WIDTH-1:0] line_position_ff, line_position_in;
   record_kind_type      record_kind_ff, record_kind_in;
   logic [7:0]           byte_count_ff, byte_count_in;
   logic [31:0]          address_accum_ff, address_accum_in;
   logic [7:0]           data_remaining_ff, data_remaining_in;
   logic [3:0]           high_nibble_ff, high_nibble_in;
   logic                 halted_ff, halted_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_result_kind_ff, rsp_result_kind_in;
   logic [31:0]          rsp_address_ff, rsp_address_in;
   logic [7:0]           rsp_data_byte_ff, rsp_data_byte_in;

   logic                 accept;
   logic                 produced;
   logic [3:0]           nib;
   logic [7:0]           new_count;
   logic [POS_WIDTH-1:0] first_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign nib = hex_value(req_character);
   assign new_count = {byte_count_ff[3:0], nib};
   assign first_data = data_start(record_kind_ff);

   always_comb begin
      line_position_in = line_position_ff;
      record_kind_in = record_kind_ff;
      byte_count_in = byte_count_ff;
      address_accum_in = address_accum_ff;
      data_remaining_in = data_remaining_ff;
      high_nibble_in = high_nibble_ff;
      halted_in = halted_ff;
      produced = 1'b0;
      rsp_result_kind_in = RESULT_WRITE;
      rsp_address_in = address_accum_ff;
      rsp_data_byte_in = {high_nibble_ff, nib};

      if (accept && !halted_ff) begin
         if (line_position_ff != POS_MAX) begin
            line_position_in = line_position_ff + POS_WIDTH'(1);
         end
         priority if (line_position_ff == POS_WIDTH'(0)) begin
            record_kind_in = REC_NONE;
            byte_count_in = 8'd0;
            address_accum_in = 32'd0;
            data_remaining_in = 8'd0;
            high_nibble_in = 4'd0;
            if (req_character != CHAR_S) begin
               // bad line start halts the parser until reset
               halted_in = 1'b1;
               line_position_in = POS_WIDTH'(0);
               produced = 1'b1;
               rsp_result_kind_in = RESULT_ERROR;
               rsp_address_in = 32'd0;
               rsp_data_byte_in = 8'd0;
            end
         end else if (req_character == CHAR_LINE_END) begin
            line_position_in = POS_WIDTH'(0);
            record_kind_in = REC_NONE;
            byte_count_in = 8'd0;
            address_accum_in = 32'd0;
            data_remaining_in = 8'd0;
            high_nibble_in = 4'd0;
         end else if (line_position_ff == POS_WIDTH'(1)) begin
            priority if (req_character == CHAR_ONE) begin
               record_kind_in = REC_S1;
            end else if (req_character == CHAR_TWO) begin
               record_kind_in = REC_S2;
            end else if (req_character == CHAR_THREE) begin
               record_kind_in = REC_S3;
            end else begin
               record_kind_in = REC_NONE;
            end
         end else if (line_position_ff == POS_WIDTH'(2)) begin
            byte_count_in = {4'd0, nib};
         end else if (line_position_ff == POS_WIDTH'(3)) begin
            byte_count_in = new_count;
            if (record_kind_ff != REC_NONE) begin
               data_remaining_in = (new_count > overhead(record_kind_ff)) ?
                  new_count - overhead(record_kind_ff) : 8'd0;
            end
         end else if (record_kind_ff != REC_NONE) begin
            if (line_position_ff < first_data) begin
               address_accum_in = {address_accum_ff[27:0], nib};
            end else if (data_remaining_ff != 8'd0) begin
               // data start is even, so the low position bit picks the digit
               if (!line_position_ff[0]) begin
                  high_nibble_in = nib;
               end else begin
                  produced = 1'b1;
                  address_accum_in = address_accum_ff + 32'd1;
                  data_remaining_in = data_remaining_ff - 8'd1;
               end
            end
         end else begin
            // ignored record type: only the position advances
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = produced;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_position_ff <= POS_WIDTH'(0);
         record_kind_ff <= REC_NONE;
         byte_count_ff <= 8'd0;
         address_accum_ff <= 32'd0;
         data_remaining_ff <= 8'd0;
         high_nibble_ff <= 4'd0;
         halted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_position_ff <= line_position_in;
         record_kind_ff <= record_kind_in;
         byte_count_ff <= byte_count_in;
         address_accum_ff <= address_accum_in;
         data_remaining_ff <= data_remaining_in;
         high_nibble_ff <= high_nibble_in;
         halted_ff <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produced) begin
         rsp_result_kind_ff <= rsp_result_kind_in;
         rsp_address_ff <= rsp_address_in;
         rsp_data_byte_ff <= rsp_data_byte_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_result_kind_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_data_byte = rsp_data_byte_ff;

endmodule

/* sv/srec_checker.sv */
// port-level checker for the s-record parser and its bind
module srec_checker
   import srec_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_character,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [31:0] rsp_address,
   input logic [7:0]  rsp_data_byte
);

   // a result held back keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_address) && $stable(rsp_data_byte))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_error_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RESULT_ERROR |->
         rsp_address == 32'd0 && rsp_data_byte == 8'd0)
      else $error("error transaction carries nonzero payload");

   // the parser halts after an error
   a_halt_after_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_result_kind == RESULT_ERROR |=> !rsp_valid)
      else $error("result after format error");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no pending result");

endmodule

bind srec_record_parser_top srec_checker u_srec_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_character(req_character),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_result_kind(rsp_result_kind),
   .rsp_address(rsp_address),
   .rsp_data_byte(rsp_data_byte)
);

/* verif/tb.sv */
// testbench for the s-record parser: table-driven opening lines, random records, final halt check
module tb
   import srec_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS = 10;
   localparam int LONG_LINE_CHARS = 1100;

   typedef struct packed {
      logic        kind;
      logic [31:0] addr;
      logic [7:0]  data;
   } mem_write_t;

   typedef struct packed {
      logic [7:0] ch;
      logic       hit;
      mem_write_t res;
   } char_row_t;

   localparam mem_write_t NO_WRITE = '{RESULT_WRITE, 32'h0, 8'h0};

   // an s3 line at the top of the address space, then an s1 line cut short after one byte
   localparam char_row_t OPENING_ROWS [0:25] = '{
      '{"S", 1'b0, NO_WRITE}, '{"3", 1'b0, NO_WRITE}, '{"0", 1'b0, NO_WRITE},
      '{"6", 1'b0, NO_WRITE}, '{"F", 1'b0, NO_WRITE}, '{"F", 1'b0, NO_WRITE},
      '{"F", 1'b0, NO_WRITE}, '{"F", 1'b0, NO_WRITE}, '{"F", 1'b0, NO_WRITE},
      '{"F", 1'b0, NO_WRITE}, '{"F", 1'b0, NO_WRITE}, '{"F", 1'b0, NO_WRITE},
      '{"f", 1'b0, NO_WRITE},
      '{"F", 1'b1, '{RESULT_WRITE, 32'hFFFF_FFFF, 8'hFF}},
      '{CHAR_LINE_END, 1'b0, NO_WRITE},
      '{"S", 1'b0, NO_WRITE}, '{"1", 1'b0, NO_WRITE}, '{"0", 1'b0, NO_WRITE},
      '{"5", 1'b0, NO_WRITE}, '{"0", 1'b0, NO_WRITE}, '{"0", 1'b0, NO_WRITE},
      '{"0", 1'b0, NO_WRITE}, '{"0", 1'b0, NO_WRITE}, '{"9", 1'b0, NO_WRITE},
      '{"g", 1'b1, '{RESULT_WRITE, 32'h0, 8'h90}},
      '{CHAR_LINE_END, 1'b0, NO_WRITE}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_character = 8'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_data_byte;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int chars_sent = 0;
   int mismatches = 0;
   int cycle_count = 0;

   mem_write_t pending_writes [$];

   // parser state as predicted
   logic [POS_WIDTH-1:0] line_pos;
   record_kind_type      rec_kind;
   logic [7:0]           rec_count;
   logic [31:0]          write_addr;
   logic [7:0]           bytes_left;
   logic [3:0]           upper_nib;
   logic                 halted;

   srec_record_parser_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_character(req_character),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_address(rsp_address),
      .rsp_data_byte(rsp_data_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [3:0] digit_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c[3:0];
      // upper and lower case letters share the low nibble pattern 1..6
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return c[3:0] + 4'd9;
      return 4'd0;
   endfunction

   function automatic void clear_line_state();
      line_pos = '0;
      rec_kind = REC_NONE;
      rec_count = 8'h0;
      write_addr = 32'h0;
      bytes_left = 8'h0;
      upper_nib = 4'h0;
   endfunction

   function automatic logic srec_decode(input logic [7:0] c, output mem_write_t res);
      logic [3:0] nib;
      logic [7:0] ovh;
      logic [POS_WIDTH-1:0] first_data;
      logic hit;
      nib = digit_of(c);
      res = NO_WRITE;
      hit = 1'b0;
      if (halted) return 1'b0;
      if (line_pos == 0) begin
         clear_line_state();
         if (c != CHAR_S) begin
            halted = 1'b1;
            res.kind = RESULT_ERROR;
            return 1'b1;
         end
      end else if (c == CHAR_LINE_END) begin
         clear_line_state();
         return 1'b0;
      end else if (line_pos == 1) begin
         case (c)
            CHAR_ONE: rec_kind = REC_S1;
            CHAR_TWO: rec_kind = REC_S2;
            CHAR_THREE: rec_kind = REC_S3;
            default: rec_kind = REC_NONE;
         endcase
      end else if (line_pos == 2) begin
         rec_count = {4'h0, nib};
      end else if (line_pos == 3) begin
         rec_count = {rec_count[3:0], nib};
         if (rec_kind != REC_NONE) begin
            ovh = 8'(rec_kind) + 8'd2;
            bytes_left = (rec_count > ovh) ? rec_count - ovh : 8'h0;
         end
      end else if (rec_kind != REC_NONE) begin
         first_data = POS_WIDTH'(2 * int'(rec_kind) + 6);
         if (line_pos < first_data) begin
            write_addr = {write_addr[27:0], nib};
         end else if (bytes_left != 0) begin
            // data starts at an even position, so even positions hold the upper digit
            if (line_pos[0] == 1'b0) begin
               upper_nib = nib;
            end else begin
               res = '{RESULT_WRITE, write_addr, {upper_nib, nib}};
               write_addr = write_addr + 32'd1;
               bytes_left = bytes_left - 8'd1;
               hit = 1'b1;
            end
         end
      end
      if (line_pos != POS_MAX) line_pos = line_pos + 1'b1;
      return hit;
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      // a stray newline would end the line early
      if (c == CHAR_LINE_END) c = CHAR_S;
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] c;
      if ($urandom_range(0, 24) == 0) return junk_char();
      if (v < 4'd10) c = 8'h30 + 8'(v);
      else c = 8'h37 + 8'(v);
      if (v >= 4'd10 && $urandom_range(0, 1) == 1) c = c + 8'h20;
      return c;
   endfunction

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_char(input logic [7:0] c, input logic typed = 1'b0,
                            input logic row_hit = 1'b0, input mem_write_t row_res = '0);
      mem_write_t predicted;
      logic hit;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_character <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      hit = srec_decode(c, predicted);
      if (typed) begin
         hit = row_hit;
         predicted = row_res;
      end
      if (hit) pending_writes.push_back(predicted);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_record_line(input bit long_tail);
      logic [7:0] text [$];
      logic [31:0] addr;
      logic [7:0] count;
      logic [7:0] kind_char;
      logic [7:0] byte_val;
      int addr_digits;
      int n_data;
      int cut;
      text.push_back(CHAR_S);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            kind_char = CHAR_ONE;
            addr_digits = 4;
         end
         3, 4: begin
            kind_char = CHAR_TWO;
            addr_digits = 6;
         end
         5, 6: begin
            kind_char = CHAR_THREE;
            addr_digits = 8;
         end
         7: begin
            kind_char = 8'h30 + 8'($urandom_range(0, 9));
            addr_digits = $urandom_range(4, 8);
         end
         default: begin
            kind_char = junk_char();
            addr_digits = $urandom_range(4, 8);
         end
      endcase
      n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      count = 8'(addr_digits / 2 + 1 + n_data);
      if ($urandom_range(0, 6) == 0) count = 8'($urandom_range(0, 255));
      addr = $urandom();
      if ($urandom_range(0, 4) == 0) addr = 32'hFFFF_FFFF - 32'($urandom_range(0, 8));
      text.push_back(kind_char);
      text.push_back(hex_char(count[7:4]));
      text.push_back(hex_char(count[3:0]));
      for (int i = addr_digits - 1; i >= 0; i--) text.push_back(hex_char(4'(addr >> (4 * i))));
      // data bytes then the checksum
      repeat (n_data + 1) begin
         byte_val = 8'($urandom());
         text.push_back(hex_char(byte_val[7:4]));
         text.push_back(hex_char(byte_val[3:0]));
      end
      if (long_tail) while (text.size() < LONG_LINE_CHARS) text.push_back(junk_char());
      if (text.size() > 1 && $urandom_range(0, 6) == 0) begin
         cut = $urandom_range(1, text.size() - 1);
         while (text.size() > cut) void'(text.pop_back());
      end
      text.push_back(CHAR_LINE_END);
      foreach (text[i]) send_char(text[i]);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int char_budget,
                            input bit with_long_line);
      int first;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first = chars_sent;
      if (with_long_line) send_record_line(1'b1);
      while (chars_sent - first < char_budget) send_record_line(1'b0);
      // hold off until the parser has delivered everything
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_writes.size() != 0);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      mem_write_t got;
      mem_write_t want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_result_kind, rsp_address, rsp_data_byte};
         if (pending_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected transaction: kind %0d addr %h data %h",
                        got.kind, got.addr, got.data);
         end else begin
            want = pending_writes.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: expected kind %0d addr %h data %h, got kind %0d addr %h data %h",
                           want.kind, want.addr, want.data, got.kind, got.addr, got.data);
            end
         end
      end
   end

   initial begin
      clear_line_state();
      halted = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (OPENING_ROWS[i])
         send_char(OPENING_ROWS[i].ch, 1'b1, OPENING_ROWS[i].hit, OPENING_ROWS[i].res);
      run_phase(9, 78, 200, 1'b0);
      run_phase(78, 9, 200, 1'b0);
      run_phase(0, 0, 200, 1'b1);
      // an empty line halts the parser for the rest of the run
      send_char(CHAR_LINE_END, 1'b1, 1'b1, '{RESULT_ERROR, 32'h0, 8'h0});
      repeat (12) send_char(8'($urandom_range(0, 255)));
      send_char(CHAR_S);
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_writes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* srec_record_parser_top.f */
sv/srec_pkg.sv
sv/srec_record_parser_top.sv
sv/srec_checker.sv
verif/tb.sv
